### src/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under the clock, switched off while reset is asserted.
`define LFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication: the consequent must hold in the same cycle.
`define LFP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication: the consequent must hold in the next cycle.
`define LFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and the CRC-8 step function of the range sensor
// frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  // Frame synchronisation byte.
  localparam logic [7:0] HEADER_BYTE = 8'h54;
  // CRC-8 polynomial, MSB first, initial value zero, no final inversion.
  localparam logic [7:0] CRC_POLY = 8'h4D;
  // Most measurement points that one frame carries.
  localparam int unsigned MAX_POINTS = 12;

  // Fixed byte offsets at the head of a frame.
  localparam int unsigned SPEED_OFS = 2;
  localparam int unsigned START_OFS = 4;
  localparam int unsigned PT_START  = 6;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_CRC = 1'b1;

  // One finished frame as handed from the intake to the output sequencer.
  typedef struct packed {
    logic        status;
    logic        bank;
    logic [15:0] scan_speed;
    logic [15:0] first_angle;
    logic [15:0] final_angle;
    logic [15:0] time_stamp;
  } frame_desc_t;

  // Output sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_e;

  // One byte of CRC-8, a bit at a time over the eight bits.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### src/lfp_front.sv
// ----------------------------------------------------------------------------
// lfp_front
// Byte intake: hunts for the header, counts the frame, runs the CRC, keeps
// the header and trailer fields and writes the point bytes into the point store.
// ----------------------------------------------------------------------------
module lfp_front #(
  parameter int unsigned FRAME_BYTES = 47
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output lfp_pkg::frame_desc_t  push_desc_o,
  output logic                  wr_en_o,
  output logic [$clog2(2 * 3 * ((((FRAME_BYTES - 11) / 3) > lfp_pkg::MAX_POINTS) ?
                lfp_pkg::MAX_POINTS : ((FRAME_BYTES - 11) / 3))) - 1:0] wr_addr_o,
  output logic [7:0]            wr_data_o
);

  localparam int unsigned NPTS_RAW = (FRAME_BYTES - 11) / 3;
  localparam int unsigned NPTS     = (NPTS_RAW > lfp_pkg::MAX_POINTS) ?
                                     lfp_pkg::MAX_POINTS : NPTS_RAW;
  localparam int unsigned PT_BYTES = 3 * NPTS;
  localparam int unsigned AW       = $clog2(2 * PT_BYTES);
  localparam int unsigned CNT_W    = $clog2(FRAME_BYTES);
  localparam int unsigned END_OFS  = FRAME_BYTES - 5;
  localparam int unsigned TS_OFS   = FRAME_BYTES - 3;

  logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]       crc_q, crc_d, crc_next;
  logic             bank_q, bank_d;
  logic [15:0]      speed_q, start_q, end_q, ts_q;
  logic             accept, take, frame_end, in_points;
  logic [AW-1:0]    pt_off;

  // Intake stalls only while both point banks are held by finished frames.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = accept && ((byte_cnt_q != '0) || (rx_byte_i == lfp_pkg::HEADER_BYTE));
  assign frame_end  = take && (byte_cnt_q == CNT_W'(FRAME_BYTES - 1));
  assign crc_next   = lfp_pkg::crc8_step(crc_q, rx_byte_i);

  // Counter, CRC and bank select.
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    crc_d      = crc_q;
    bank_d     = bank_q;
    if (frame_end) begin
      byte_cnt_d = '0;
      crc_d      = '0;
      bank_d     = !bank_q;
    end else if (take) begin
      byte_cnt_d = byte_cnt_q + CNT_W'(1);
      crc_d      = crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      crc_q      <= '0;
      bank_q     <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      crc_q      <= crc_d;
      bank_q     <= bank_d;
    end
  end

  // Header and trailer fields, little-endian, captured as they pass.
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (byte_cnt_q == CNT_W'(lfp_pkg::SPEED_OFS))     speed_q[7:0]  <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(lfp_pkg::SPEED_OFS + 1)) speed_q[15:8] <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(lfp_pkg::START_OFS))     start_q[7:0]  <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(lfp_pkg::START_OFS + 1)) start_q[15:8] <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(END_OFS))                end_q[7:0]    <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(END_OFS + 1))            end_q[15:8]   <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(TS_OFS))                 ts_q[7:0]     <= rx_byte_i;
      if (byte_cnt_q == CNT_W'(TS_OFS + 1))             ts_q[15:8]    <= rx_byte_i;
    end
  end

  // Point bytes go to the current bank of the point store.
  assign in_points = (byte_cnt_q >= CNT_W'(lfp_pkg::PT_START)) &&
                     (byte_cnt_q <  CNT_W'(lfp_pkg::PT_START + PT_BYTES));
  assign pt_off    = AW'(byte_cnt_q - CNT_W'(lfp_pkg::PT_START));
  assign wr_en_o   = take && in_points;
  assign wr_addr_o = bank_q ? (pt_off + AW'(PT_BYTES)) : pt_off;
  assign wr_data_o = rx_byte_i;

  // Frame descriptor; a failed frame carries zero fields.
  always_comb begin
    push_o                  = frame_end;
    push_desc_o.status      = (crc_next != 8'h00) ? lfp_pkg::STATUS_CRC : lfp_pkg::STATUS_OK;
    push_desc_o.bank        = bank_q;
    push_desc_o.scan_speed  = speed_q;
    push_desc_o.first_angle = start_q;
    push_desc_o.final_angle = end_q;
    push_desc_o.time_stamp  = ts_q;
    if (crc_next != 8'h00) begin
      push_desc_o.scan_speed  = '0;
      push_desc_o.first_angle = '0;
      push_desc_o.final_angle = '0;
      push_desc_o.time_stamp  = '0;
    end
  end

endmodule

### src/lfp_queue.sv
// ----------------------------------------------------------------------------
// lfp_queue
// Two-entry queue of finished frame descriptors between intake and output.
// ----------------------------------------------------------------------------
module lfp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lfp_pkg::frame_desc_t push_desc_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output lfp_pkg::frame_desc_t head_o
);

  lfp_pkg::frame_desc_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

### src/lfp_back.sv
// ----------------------------------------------------------------------------
// lfp_back
// Output sequencer: holds the two-bank point store, reads each point's three
// bytes and drives the result register.
// ----------------------------------------------------------------------------
module lfp_back #(
  parameter int unsigned FRAME_BYTES = 47
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [$clog2(2 * 3 * ((((FRAME_BYTES - 11) / 3) > lfp_pkg::MAX_POINTS) ?
                lfp_pkg::MAX_POINTS : ((FRAME_BYTES - 11) / 3))) - 1:0] wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 q_valid_i,
  input  lfp_pkg::frame_desc_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [3:0]           point_index_o,
  output logic [15:0]          distance_o,
  output logic [7:0]           confidence_o,
  output logic [15:0]          scan_speed_o,
  output logic [15:0]          first_angle_o,
  output logic [15:0]          final_angle_o,
  output logic [15:0]          time_stamp_o,
  output logic                 last_o
);

  localparam int unsigned NPTS_RAW = (FRAME_BYTES - 11) / 3;
  localparam int unsigned NPTS     = (NPTS_RAW > lfp_pkg::MAX_POINTS) ?
                                     lfp_pkg::MAX_POINTS : NPTS_RAW;
  localparam int unsigned PT_BYTES = 3 * NPTS;
  localparam int unsigned DEPTH    = 2 * PT_BYTES;
  localparam int unsigned AW       = $clog2(DEPTH);

  lfp_pkg::back_state_e state_q, state_d;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [1:0]    sel_q, sel_d;
  logic [3:0]    pt_q, pt_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] rd_off, rd_addr;
  logic          rd_en, load, last_pt;
  logic [7:0]    dist_lo_q, dist_hi_q, conf_q;
  logic          out_valid_q;

  assign last_pt = head_i.status || (pt_q == 4'(NPTS - 1));
  assign rd_off  = base_q + AW'(sel_q);
  assign rd_addr = head_i.bank ? (rd_off + AW'(PT_BYTES)) : rd_off;
  assign load    = (state_q == lfp_pkg::BK_EMIT) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfp_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = head_i.status ? lfp_pkg::BK_EMIT : lfp_pkg::BK_FETCH;
        end
      end
      lfp_pkg::BK_FETCH: begin
        if (sel_q == 2'd3) begin
          state_d = lfp_pkg::BK_EMIT;
        end
      end
      lfp_pkg::BK_EMIT: begin
        if (load) begin
          state_d = last_pt ? lfp_pkg::BK_IDLE : lfp_pkg::BK_FETCH;
        end
      end
      default: state_d = lfp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    rd_en  = 1'b0;
    pop_o  = 1'b0;
    sel_d  = sel_q;
    pt_d   = pt_q;
    base_d = base_q;
    unique case (state_q)
      lfp_pkg::BK_IDLE: begin
        sel_d  = 2'd0;
        pt_d   = 4'd0;
        base_d = '0;
      end
      lfp_pkg::BK_FETCH: begin
        rd_en = (sel_q != 2'd3);
        sel_d = sel_q + 2'd1;
      end
      lfp_pkg::BK_EMIT: begin
        if (load) begin
          pop_o  = last_pt;
          sel_d  = 2'd0;
          pt_d   = pt_q + 4'd1;
          base_d = base_q + AW'(3);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfp_pkg::BK_IDLE;
      sel_q       <= 2'd0;
      pt_q        <= 4'd0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      pt_q        <= pt_d;
      base_q      <= base_d;
      out_valid_q <= load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  // Point store: one write port from the intake, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Read data lands in the cycle after its address: low, high, confidence.
  always_ff @(posedge clk_i) begin
    if (state_q == lfp_pkg::BK_FETCH) begin
      if (sel_q == 2'd1) dist_lo_q <= rdata_q;
      if (sel_q == 2'd2) dist_hi_q <= rdata_q;
      if (sel_q == 2'd3) conf_q    <= rdata_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o      <= head_i.status;
      point_index_o <= head_i.status ? 4'd0 : pt_q;
      distance_o    <= head_i.status ? 16'd0 : {dist_hi_q, dist_lo_q};
      confidence_o  <= head_i.status ? 8'd0 : conf_q;
      scan_speed_o  <= head_i.scan_speed;
      first_angle_o <= head_i.first_angle;
      final_angle_o <= head_i.final_angle;
      time_stamp_o  <= head_i.time_stamp;
      last_o        <= last_pt;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/lidar_frame_parser_crc8.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_crc8
// Range sensor frame parser: finds the header, gathers a frame while checking
// its CRC-8 and emits one word per measurement point, or one error word.
//
//   channel | handshake               | words
//   --------+-------------------------+----------------------------------------
//   input   | in_valid_i / in_ready_o | rx_byte_i, one received byte
//   output  | out_valid_o/out_ready_i | status_o .. last_o, one point or error
//
// The intake takes one byte a cycle while the descriptor queue has room.
// The output sequencer reads a point's three bytes from the point store in its
// fetch state, then loads the result register in its emit state; each frame
// also passes the idle state, and an error word skips the fetch state.
// Two finished frames may wait; with both point banks held, in_ready_o drops.
// Reset clears counters, CRC, queue and sequencer; the point store needs no
// clearing. Stalls on either side are absorbed by the queue and output register.
// ----------------------------------------------------------------------------
module lidar_frame_parser_crc8 #(
  parameter int unsigned FRAME_BYTES = 47
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [3:0]  point_index_o,
  output logic [15:0] distance_o,
  output logic [7:0]  confidence_o,
  output logic [15:0] scan_speed_o,
  output logic [15:0] first_angle_o,
  output logic [15:0] final_angle_o,
  output logic [15:0] time_stamp_o,
  output logic        last_o
);

  localparam int unsigned NPTS_RAW = (FRAME_BYTES - 11) / 3;
  localparam int unsigned NPTS     = (NPTS_RAW > lfp_pkg::MAX_POINTS) ?
                                     lfp_pkg::MAX_POINTS : NPTS_RAW;
  localparam int unsigned AW       = $clog2(2 * 3 * NPTS);

  logic                 q_full, q_valid, push, pop;
  lfp_pkg::frame_desc_t push_desc, head;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;

  // Byte intake and CRC check.
  lfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Finished frames waiting for the output side.
  lfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Point readout and result register.
  lfp_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_addr_i     (wr_addr),
    .wr_data_i     (wr_data),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .point_index_o (point_index_o),
    .distance_o    (distance_o),
    .confidence_o  (confidence_o),
    .scan_speed_o  (scan_speed_o),
    .first_angle_o (first_angle_o),
    .final_angle_o (final_angle_o),
    .time_stamp_o  (time_stamp_o),
    .last_o        (last_o)
  );

endmodule

### src/lfp_checker.sv
// ----------------------------------------------------------------------------
// lfp_checker
// Port-level checks of the frame parser's result stream, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [3:0]  point_index_o,
  input logic [15:0] distance_o,
  input logic [7:0]  confidence_o,
  input logic [15:0] scan_speed_o,
  input logic [15:0] first_angle_o,
  input logic [15:0] final_angle_o,
  input logic [15:0] time_stamp_o,
  input logic        last_o
);

  logic        in_stall, out_stall, out_take, err_zero;
  logic [93:0] out_word;

  // Handshake states and the whole result word as one vector.
  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_take  = out_valid_o && out_ready_i;
  assign out_word  = {status_o, point_index_o, distance_o, confidence_o, scan_speed_o,
                      first_angle_o, final_angle_o, time_stamp_o, last_o};
  assign err_zero  = (point_index_o == 4'd0) && (distance_o == 16'd0) &&
                     (confidence_o == 8'd0) && (scan_speed_o == 16'd0) &&
                     (first_angle_o == 16'd0) && (final_angle_o == 16'd0) &&
                     (time_stamp_o == 16'd0);

  // A stalled input word holds its place and its contents.
  `LFP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(rx_byte_i), "input word changed while stalled")

  // A stalled result word holds its place and its contents.
  `LFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word), "result word changed while stalled")

  // An error word closes its frame and carries only zeros.
  `LFP_ASSERT_SAME(a_err_word, clk_i, rst_ni, out_valid_o && status_o, last_o && err_zero, "error word malformed")

  // Point numbers never pass the last point of a frame.
  `LFP_ASSERT(a_pt_range, clk_i, rst_ni, !out_valid_o || (point_index_o <= 4'd11), "point index out of range")

  // After a word that does not close its frame, the next point follows on.
  `LFP_ASSERT_NEXT(a_pt_follow, clk_i, rst_ni, out_take && !last_o, !out_valid_o || (point_index_o == $past(point_index_o) + 4'd1), "point index did not advance")

endmodule

bind lidar_frame_parser_crc8 lfp_checker u_lfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .rx_byte_i     (rx_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .point_index_o (point_index_o),
  .distance_o    (distance_o),
  .confidence_o  (confidence_o),
  .scan_speed_o  (scan_speed_o),
  .first_angle_o (first_angle_o),
  .final_angle_o (final_angle_o),
  .time_stamp_o  (time_stamp_o),
  .last_o        (last_o)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the range sensor frame parser against a frame predictor. Noise
// bytes, well-formed frames, frames with a broken checksum and truncated
// frames are sent. Every point word or error word that comes out is compared
// field by field with the oldest predicted word. Both sides idle at random.
// ----------------------------------------------------------------------------

localparam int unsigned FRAME_LEN = 47;
localparam int unsigned POINT_CNT =
    ((FRAME_LEN - 11) / 3 > lfp_pkg::MAX_POINTS) ? lfp_pkg::MAX_POINTS : (FRAME_LEN - 11) / 3;

// One output word of the parser, as the predictor expects it.
typedef struct packed {
  logic        status;
  logic [3:0]  point_index;
  logic [15:0] distance;
  logic [7:0]  confidence;
  logic [15:0] scan_speed;
  logic [15:0] first_angle;
  logic [15:0] final_angle;
  logic [15:0] time_stamp;
  logic        last;
} point_word_t;

// Frame predictor and the store of point words still to arrive.
class frame_scoreboard;
  int unsigned errors;
  int unsigned words_checked;
  int unsigned good_frames;
  int unsigned bad_frames;
  logic [5:0]  byte_cnt;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_buf [FRAME_LEN];
  point_word_t due_points [$];

  function new();
    byte_cnt = '0;
    crc_acc  = '0;
  endfunction

  // CRC-8 over one byte, most significant bit first.
  function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] acc;
    acc = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      acc = acc[7] ? ({acc[6:0], 1'b0} ^ lfp_pkg::CRC_POLY) : {acc[6:0], 1'b0};
    end
    return acc;
  endfunction

  function logic [15:0] le16(int unsigned pos);
    return {frame_buf[pos + 1], frame_buf[pos]};
  endfunction

  // Takes one accepted byte and queues the words that it completes.
  function void note_byte(logic [7:0] b);
    point_word_t w;
    int unsigned p;
    if (byte_cnt == 0 && b != lfp_pkg::HEADER_BYTE) begin
      return;
    end
    frame_buf[byte_cnt] = b;
    crc_acc = crc_next(crc_acc, b);
    byte_cnt++;
    if (byte_cnt < FRAME_LEN) begin
      return;
    end
    byte_cnt = '0;
    if (crc_acc != 8'h00) begin
      crc_acc  = '0;
      w        = '0;
      w.status = lfp_pkg::STATUS_CRC;
      w.last   = 1'b1;
      due_points.push_back(w);
      bad_frames++;
      return;
    end
    crc_acc = '0;
    good_frames++;
    for (int unsigned k = 0; k < POINT_CNT; k++) begin
      p             = lfp_pkg::PT_START + 3 * k;
      w.status      = lfp_pkg::STATUS_OK;
      w.point_index = k[3:0];
      w.distance    = le16(p);
      w.confidence  = frame_buf[p + 2];
      w.scan_speed  = le16(lfp_pkg::SPEED_OFS);
      w.first_angle = le16(lfp_pkg::START_OFS);
      w.final_angle = le16(FRAME_LEN - 5);
      w.time_stamp  = le16(FRAME_LEN - 3);
      w.last        = (k + 1 == POINT_CNT);
      due_points.push_back(w);
    end
  endfunction

  function int unsigned pending();
    return due_points.size();
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task cmp(string field, int unsigned got, int unsigned want, int unsigned idx);
    if (got != want) begin
      report($sformatf("word %0d field %s: got 0x%0h, expected 0x%0h",
                       idx, field, got, want));
    end
  endtask

  // Compares one accepted output word with the oldest prediction.
  task check_word(point_word_t w);
    point_word_t want;
    if (due_points.size() == 0) begin
      report($sformatf("word %0d arrived with nothing expected", words_checked));
      words_checked++;
      return;
    end
    want = due_points.pop_front();
    cmp("status", w.status, want.status, words_checked);
    cmp("point_index", w.point_index, want.point_index, words_checked);
    cmp("distance", w.distance, want.distance, words_checked);
    cmp("confidence", w.confidence, want.confidence, words_checked);
    cmp("scan_speed", w.scan_speed, want.scan_speed, words_checked);
    cmp("first_angle", w.first_angle, want.first_angle, words_checked);
    cmp("final_angle", w.final_angle, want.final_angle, words_checked);
    cmp("time_stamp", w.time_stamp, want.time_stamp, words_checked);
    cmp("last", w.last, want.last, words_checked);
    words_checked++;
  endtask
endclass

module testbench;

  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned WATCHDOG    = 8000;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned RAND_BYTES  = 50;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic [3:0]  point_index_o;
  logic [15:0] distance_o;
  logic [7:0]  confidence_o;
  logic [15:0] scan_speed_o;
  logic [15:0] first_angle_o;
  logic [15:0] final_angle_o;
  logic [15:0] time_stamp_o;
  logic        last_o;

  frame_scoreboard sb;
  logic [7:0]      frame_bytes [FRAME_LEN];
  bit              calm;
  bit              hold_req;
  int unsigned     bytes_sent;
  int unsigned     idle_cycles;

  lidar_frame_parser_crc8 #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .rx_byte_i(rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .point_index_o(point_index_o),
    .distance_o(distance_o),
    .confidence_o(confidence_o),
    .scan_speed_o(scan_speed_o),
    .first_angle_o(first_angle_o),
    .final_angle_o(final_angle_o),
    .time_stamp_o(time_stamp_o),
    .last_o(last_o)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] non_header_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == lfp_pkg::HEADER_BYTE) begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  // Offers one byte, waits for it to be taken, then idles at random.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_byte(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Fills the frame buffer: fixed pattern, or random with frequent extremes.
  task automatic fill_frame(input logic [7:0] pattern, input bit random_fill);
    int unsigned r;
    frame_bytes[0] = lfp_pkg::HEADER_BYTE;
    for (int unsigned i = 1; i < FRAME_LEN - 1; i++) begin
      r = $urandom_range(0, 9);
      if (!random_fill) begin
        frame_bytes[i] = pattern;
      end else if (r == 0) begin
        frame_bytes[i] = 8'h00;
      end else if (r == 1) begin
        frame_bytes[i] = 8'hFF;
      end else begin
        frame_bytes[i] = 8'($urandom);
      end
    end
  endtask

  // Seals the frame with its checksum, optionally damages a byte, sends it.
  task automatic send_frame(input bit damage);
    logic [7:0] crc;
    crc = '0;
    for (int unsigned i = 0; i < FRAME_LEN - 1; i++) begin
      crc = sb.crc_next(crc, frame_bytes[i]);
    end
    frame_bytes[FRAME_LEN - 1] = crc;
    if (damage) begin
      frame_bytes[$urandom_range(1, FRAME_LEN - 1)] ^= 8'($urandom_range(1, 255));
    end
    for (int unsigned i = 0; i < FRAME_LEN; i++) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  // Lowers valid and waits until every predicted word has been taken.
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Stimulus: directed frames, a fill-up under back-pressure, then random.
  initial begin : stimulus
    int unsigned start_cnt;
    int unsigned kind;
    int unsigned n;
    sb          = new();
    calm        = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes dropped while hunting for the header.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(lfp_pkg::HEADER_BYTE - 8'd1);
    send_byte(lfp_pkg::HEADER_BYTE + 8'd1);
    send_byte(8'hAA);
    // A good frame with every field at its top.
    fill_frame(8'hFF, 1'b0);
    send_frame(1'b0);
    // A checksum failure gives a single error word.
    fill_frame(8'h00, 1'b1);
    send_frame(1'b1);
    send_byte(8'h55);

    // The receiver holds off while frames keep coming, so the input stalls.
    // The frames carry every field at its bottom, then header bytes as data.
    calm     = 1'b1;
    hold_req = 1'b1;
    fill_frame(8'h00, 1'b0);
    send_frame(1'b0);
    fill_frame(lfp_pkg::HEADER_BYTE, 1'b0);
    send_frame(1'b0);
    repeat (3) send_byte(non_header_byte());
    calm = 1'b0;
    // The sender pauses until the block has emptied.
    drain_all();
    repeat (SETTLE) @(posedge clk_i);

    // Random part: mostly good frames, some damaged, noise and truncation.
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < RAND_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        fill_frame(8'h00, 1'b1);
        send_frame(1'b0);
      end else if (kind < 85) begin
        fill_frame(8'h00, 1'b1);
        send_frame(1'b1);
      end else if (kind < 95) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(non_header_byte());
      end else begin
        // A frame cut short; filler completes it so the stream resyncs.
        n = $urandom_range(1, 30);
        send_byte(lfp_pkg::HEADER_BYTE);
        repeat (n) send_byte(8'($urandom));
        repeat (FRAME_LEN - 1 - n) send_byte(non_header_byte());
      end
    end
    calm = 1'b0;

    drain_all();
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d bytes: %0d good frames, %0d checksum failures, %0d words checked.",
             bytes_sent, sb.good_frames, sb.bad_frames, sb.words_checked);
    $display("Covered hunting noise, in-frame header bytes, truncation and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: takes words, stalls at random, and once for a long stretch.
  initial begin : receiver
    int unsigned stall_left;
    bit          nxt_ready;
    point_word_t w;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        w.status      = status_o;
        w.point_index = point_index_o;
        w.distance    = distance_o;
        w.confidence  = confidence_o;
        w.scan_speed  = scan_speed_o;
        w.first_angle = first_angle_o;
        w.final_angle = final_angle_o;
        w.time_stamp  = time_stamp_o;
        w.last        = last_o;
        sb.check_word(w);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && !calm) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        nxt_ready = 1'b0;
        stall_left--;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Timeout after %0d cycles without progress, %0d words outstanding.",
               idle_cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
+incdir+src
src/lfp_pkg.sv
src/lfp_front.sv
src/lfp_queue.sv
src/lfp_back.sv
src/lidar_frame_parser_crc8.sv
src/lfp_checker.sv
dv/testbench.sv
